// File: rtl/core/rra_pkg.sv
// Shared types and constants for the rectangle range aggregate block.
// Holds the transfer structs, the command, kind, status and register codes.
// No dependencies.
package rra_pkg;

   localparam int COORD_W    = 6;
   localparam int VALUE_W    = 32;
   localparam int KIND_W     = 2;
   localparam int CNT_W      = 13;
   localparam int SUM_W      = 44;
   localparam int GRID_W     = 11;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CNT_W-1:0] MAX_COUNT = 13'd4096;

   localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NUMERIC = 2'd1;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_INVERTED = 2'd1;
   localparam logic [1:0] STAT_NO_AVG   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COL  = 3'd4;

   typedef enum logic [1:0] {
      OP_SUM = 2'd0,
      OP_AVG = 2'd1,
      OP_MIN = 2'd2,
      OP_MAX = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                       command;
      logic [COORD_W-1:0]         cell_row;
      logic [COORD_W-1:0]         cell_col;
      logic [KIND_W-1:0]          cell_kind;
      logic signed [VALUE_W-1:0]  cell_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  result_value;
      logic [1:0]                 status;
      logic [CNT_W-1:0]           numeric_count;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [VALUE_W-1:0]  value;
   } cell_type;

   function automatic logic signed [VALUE_W-1:0] q_sat(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-VALUE_W:0] upper;
      logic signed [VALUE_W-1:0] r;
      upper = v[SUM_W-1:VALUE_W-1];
      if (upper == '0 || upper == '1) begin
         r = signed'(v[VALUE_W-1:0]);
      end else if (v[SUM_W-1]) begin
         r = Q_MIN;
      end else begin
         r = Q_MAX;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/rra_div.sv
// Restoring divider for the average: one quotient bit per cycle.
// Divides an unsigned sum magnitude by the numeric cell count.
// Depends on rra_pkg.
module rra_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rra_pkg::SUM_W-1:0] dividend,
   input  logic [rra_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [rra_pkg::SUM_W-1:0] quotient
);
   import rra_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  step_ff;
   logic [SUM_W-1:0]      quot_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [CNT_W:0]        shifted;
   logic [CNT_W:0]        diff;
   logic                  fits;
   logic [CNT_W-1:0]      rem_in;
   logic [SUM_W-1:0]      quot_in;

   always_comb begin
      shifted = {rem_ff, quot_ff[SUM_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      rem_in  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quot_in = {quot_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= DIV_CNT_W'(SUM_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/core/rectangle_range_aggregate.sv
// Top level of the rectangle range aggregate block: cell grid memory, walk
// sequencer, accumulators and result register. Depends on rra_pkg and rra_div.
//
// A cell write is a single grid memory write and writes can follow back to back. A run
// reads the grid memory through its single read port, one cell per cycle, as
// it walks the rectangle, then passes through drain, finish and result, and
// the average adds a division in the one-bit-a-cycle divider. After reset
// the grid is swept to empty, one cell per cycle, over all
// 2^(clog2(ROWS)+clog2(COLS)) cells (4096 at 64 x 64); no item is taken
// during the sweep, but configuration writes are.
module rectangle_range_aggregate #(
   parameter int ROWS = 64,
   parameter int COLS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rra_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rra_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [rra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rra_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rra_pkg::*;

   localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CB    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int AW    = RB + CB;
   localparam int DEPTH = 2 ** AW;

   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic [COORD_W-1:0]      top_ff, left_ff, bottom_ff, right_ff;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [COORD_W-1:0]      row_ff, row_in, col_ff, col_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [VALUE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [VALUE_W-1:0] res_ff, res_in;
   logic [1:0]              stat_ff, stat_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_type                 rsp_ff, rsp_in;

   cell_type                mem [DEPTH];
   cell_type                rd_data_ff;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   cell_type                wr_cell;
   logic [AW-1:0]           rd_addr;

   logic [GRID_W-1:0]       walk_row_ext, walk_col_ext, req_row_ext, req_col_ext;
   logic                    walk_in_grid, req_in_grid;

   logic                    div_start, div_done;
   logic [SUM_W-1:0]        sum_mag, div_quot;
   logic signed [SUM_W-1:0] avg_val;

   assign walk_row_ext = GRID_W'(row_ff);
   assign walk_col_ext = GRID_W'(col_ff);
   assign req_row_ext  = GRID_W'(req_data.cell_row);
   assign req_col_ext  = GRID_W'(req_data.cell_col);
   assign walk_in_grid = (walk_row_ext < GRID_W'(ROWS)) && (walk_col_ext < GRID_W'(COLS));
   assign req_in_grid  = (req_row_ext < GRID_W'(ROWS)) && (req_col_ext < GRID_W'(COLS));
   assign rd_addr      = {walk_row_ext[RB-1:0], walk_col_ext[CB-1:0]};

   assign sum_mag = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign avg_val = sum_ff[SUM_W-1] ? -signed'(div_quot) : signed'(div_quot);

   rra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_cell;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rd_vld_in  = 1'b0;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      cnt_in     = cnt_ff;
      res_in     = res_ff;
      stat_in    = stat_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_in     = rsp_ff;
      div_start  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = {req_row_ext[RB-1:0], req_col_ext[CB-1:0]};
      wr_cell    = '{kind: req_data.cell_kind, value: req_data.cell_value};

      if (rd_vld_ff && rd_data_ff.kind == KIND_NUMERIC) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff.value);
         cnt_in = cnt_ff + CNT_W'(1);
         if (rd_data_ff.value < min_ff) begin
            min_in = rd_data_ff.value;
         end
         if (rd_data_ff.value > max_ff) begin
            max_in = rd_data_ff.value;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_cell = '{kind: KIND_EMPTY, value: '0};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_WRITE) begin
                  wr_en = req_in_grid;
               end else if (top_ff > bottom_ff || left_ff > right_ff) begin
                  res_in   = '0;
                  cnt_in   = '0;
                  stat_in  = STAT_INVERTED;
                  state_in = ST_DONE;
               end else begin
                  row_in   = top_ff;
                  col_in   = left_ff;
                  sum_in   = '0;
                  min_in   = Q_MAX;
                  max_in   = Q_MIN;
                  cnt_in   = '0;
                  stat_in  = STAT_OK;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rd_vld_in = walk_in_grid;
            if (row_ff == bottom_ff) begin
               row_in = top_ff;
               if (col_ff == right_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_SUM: res_in = q_sat(sum_ff);
               OP_AVG: begin
                  if (cnt_ff == '0) begin
                     res_in  = '0;
                     stat_in = STAT_NO_AVG;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_MIN: res_in = min_ff;
               default: res_in = max_ff;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = q_sat(avg_val);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in           = 1'b1;
               rsp_in.result_value  = (stat_ff == STAT_OK) ? res_ff : '0;
               rsp_in.status        = stat_ff;
               rsp_in.numeric_count = (stat_ff == STAT_OK) ? cnt_ff : '0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         op_ff      <= OP_SUM;
         top_ff     <= '0;
         left_ff    <= '0;
         bottom_ff  <= '0;
         right_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_OP_MODE:    op_ff     <= op_type'(csr_wdata[1:0]);
               CSR_TOP_ROW:    top_ff    <= csr_wdata[COORD_W-1:0];
               CSR_LEFT_COL:   left_ff   <= csr_wdata[COORD_W-1:0];
               CSR_BOTTOM_ROW: bottom_ff <= csr_wdata[COORD_W-1:0];
               CSR_RIGHT_COL:  right_ff  <= csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      sum_ff  <= sum_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/rra_chk.sv
// Port-level checks for the rectangle range aggregate block, bound to its top.
// Depends on rra_pkg and rectangle_range_aggregate.
module rra_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input rra_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input rra_pkg::rsp_type               rsp_data,
   input logic                           csr_write_en,
   input logic [rra_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [rra_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rra_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result transfer dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("Stalled result payload changed.");

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_RUN |=> req_stall)
      else $error("Input taken while a run was in progress.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         rsp_data.result_value == '0 && rsp_data.numeric_count == '0)
      else $error("Error result carries a value or a count.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.numeric_count <= MAX_COUNT)
      else $error("Numeric count exceeds the largest rectangle.");

endmodule

bind rectangle_range_aggregate rra_chk u_rra_chk (.*);

// File: bench/rectangle_range_aggregate_tb.sv
// Self-checking bench for rectangle_range_aggregate: cell writes and rectangle runs are
// predicted inside the bench, and each result transfer is compared in order of arrival.
// Depends on rra_pkg and the rectangle_range_aggregate RTL.
`timescale 1ns / 1ps

module rectangle_range_aggregate_tb;
   import rra_pkg::*;

   localparam int GRID_ROWS     = 64;
   localparam int GRID_COLS     = 64;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int CYCLE_LIMIT   = 6000000;
   localparam int SETTLE_CYCLES = 60;
   localparam int WRITE_SETTLE  = 8;
   localparam int LONG_HOLD     = 400;

   localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit [KIND_W-1:0]         kind_grid [GRID_ROWS][GRID_COLS];
   bit signed [VALUE_W-1:0] value_grid [GRID_ROWS][GRID_COLS];
   op_type                  area_op = OP_SUM;
   int                      area_top, area_left, area_bottom, area_right;

   rsp_type pending_results[$];
   int      errors;
   int      cycle_count;
   int      items_sent;
   int      rsp_hold;
   int      rsp_wait;
   bit      send_quiet;
   bit      recv_quiet;

   rectangle_range_aggregate dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic signed [VALUE_W-1:0] clip_q(input longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[VALUE_W-1:0];
   endfunction

   function automatic rsp_type aggregate_rect();
      rsp_type    r;
      longint     total, lo, hi, cur, agg;
      int         count;
      logic [1:0] stat;
      total = 0;
      lo = longint'(Q_MAX);
      hi = longint'(Q_MIN);
      agg = 0;
      count = 0;
      stat = STAT_OK;
      if (area_top > area_bottom || area_left > area_right) begin
         stat = STAT_INVERTED;
      end else begin
         for (int c = area_left; c <= area_right; c++) begin
            for (int rw = area_top; rw <= area_bottom; rw++) begin
               if (kind_grid[rw][c] == KIND_NUMERIC) begin
                  cur = longint'(value_grid[rw][c]);
                  total += cur;
                  if (cur < lo) lo = cur;
                  if (cur > hi) hi = cur;
                  count++;
               end
            end
         end
         case (area_op)
            OP_SUM: begin
               agg = longint'(clip_q(total));
            end
            OP_AVG: begin
               if (count == 0) stat = STAT_NO_AVG;
               else agg = longint'(clip_q(total / longint'(count)));
            end
            OP_MIN: begin
               agg = lo;
            end
            default: begin
               agg = hi;
            end
         endcase
      end
      if (stat != STAT_OK) begin
         agg = 0;
         count = 0;
      end
      r.result_value = agg[VALUE_W-1:0];
      r.status = stat;
      r.numeric_count = count[CNT_W-1:0];
      return r;
   endfunction

   function automatic void take_item(input req_type item);
      if (item.command == CMD_WRITE) begin
         kind_grid[item.cell_row][item.cell_col] = item.cell_kind;
         value_grid[item.cell_row][item.cell_col] = item.cell_value;
      end else begin
         pending_results.push_back(aggregate_rect());
      end
   endfunction

   function automatic req_type cell_item(input int row, input int col,
                                         input logic [KIND_W-1:0] kind,
                                         input logic signed [VALUE_W-1:0] value);
      req_type item;
      item.command = CMD_WRITE;
      item.cell_row = COORD_W'(row);
      item.cell_col = COORD_W'(col);
      item.cell_kind = kind;
      item.cell_value = value;
      return item;
   endfunction

   function automatic req_type run_item();
      req_type item;
      item.command = CMD_RUN;
      item.cell_row = COORD_W'($urandom);
      item.cell_col = COORD_W'($urandom);
      item.cell_kind = KIND_W'($urandom);
      item.cell_value = $urandom;
      return item;
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return $urandom;
         3: return $urandom_range(0, 2047) - 1024;
         4: return $signed($urandom) >>> 12;
         default: return '0;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] rand_kind();
      if ($urandom_range(0, 9) < 6) return KIND_NUMERIC;
      return KIND_W'($urandom_range(0, 3));
   endfunction

   // The caller is at a falling edge; the task returns at a falling edge with valid still high.
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      take_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   // Writes go straight into the grid memory, so a short settle after the last result makes the block idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (WRITE_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_OP_MODE:    area_op = op_type'(data[1:0]);
         CSR_TOP_ROW:    area_top = int'(data);
         CSR_LEFT_COL:   area_left = int'(data);
         CSR_BOTTOM_ROW: area_bottom = int'(data);
         CSR_RIGHT_COL:  area_right = int'(data);
         default: ;
      endcase
   endtask

   task automatic set_area(input op_type op, input int top, input int left,
                           input int bottom, input int right);
      write_reg(CSR_OP_MODE, CSR_DATA_W'(op));
      write_reg(CSR_TOP_ROW, CSR_DATA_W'(top));
      write_reg(CSR_LEFT_COL, CSR_DATA_W'(left));
      write_reg(CSR_BOTTOM_ROW, CSR_DATA_W'(bottom));
      write_reg(CSR_RIGHT_COL, CSR_DATA_W'(right));
   endtask

   task automatic test_empty_grid();
      send_item(run_item());
      wait_idle();
      set_area(OP_MIN, 0, 0, GRID_ROWS - 1, GRID_COLS - 1);
      send_item(run_item());
      wait_idle();
      write_reg(CSR_OP_MODE, CSR_DATA_W'(OP_MAX));
      send_item(run_item());
      wait_idle();
      write_reg(CSR_OP_MODE, CSR_DATA_W'(OP_AVG));
      send_item(run_item());
   endtask

   task automatic test_field_extremes();
      op_type op;
      send_item(cell_item(0, 0, KIND_NUMERIC, Q_MAX));
      send_item(cell_item(GRID_ROWS - 1, GRID_COLS - 1, KIND_NUMERIC, Q_MIN));
      send_item(cell_item(0, GRID_COLS - 1, KIND_NUMERIC, 32'sh0001_8000));
      send_item(cell_item(GRID_ROWS - 1, 0, KIND_TEXT, Q_MAX));
      send_item(cell_item(31, 32, KIND_SPARE, Q_MIN));
      send_item(cell_item(1, 0, KIND_NUMERIC, -32'sd3));
      for (int i = 0; i < 4; i++) begin
         op = op_type'(i);
         wait_idle();
         set_area(op, 0, 0, GRID_ROWS - 1, GRID_COLS - 1);
         send_item(run_item());
      end
      for (int r = 10; r < 12; r++) begin
         for (int c = 20; c < 22; c++) begin
            send_item(cell_item(r, c, KIND_NUMERIC, Q_MAX));
         end
      end
      wait_idle();
      set_area(OP_SUM, 10, 20, 11, 21);
      send_item(run_item());
      wait_idle();
      write_reg(CSR_OP_MODE, CSR_DATA_W'(OP_AVG));
      send_item(run_item());
   endtask

   task automatic test_inverted_area();
      wait_idle();
      set_area(OP_SUM, 5, 0, 4, 10);
      send_item(run_item());
      wait_idle();
      set_area(OP_MIN, 0, GRID_COLS - 1, GRID_ROWS - 1, 0);
      send_item(run_item());
      wait_idle();
      set_area(OP_AVG, GRID_ROWS - 1, GRID_COLS - 1, 0, 0);
      send_item(run_item());
   endtask

   task automatic test_unknown_register();
      wait_idle();
      set_area(OP_MAX, 0, 0, 1, 1);
      for (int i = CSR_RIGHT_COL + 1; i < 2 ** CSR_IDX_W; i++) begin
         write_reg(CSR_IDX_W'(i), '1);
      end
      send_item(run_item());
   endtask

   task automatic test_random_traffic();
      int     phase, burst, start, pick;
      int     h, w, top, left;
      op_type op;
      start = items_sent;
      phase = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         wait_idle();
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         op = op_type'($urandom_range(0, 3));
         if (phase % 25 == 24) begin
            h = $urandom_range(33, GRID_ROWS);
            w = $urandom_range(33, GRID_COLS);
         end else begin
            h = $urandom_range(1, 8);
            w = $urandom_range(1, 8);
         end
         top = $urandom_range(0, GRID_ROWS - h);
         left = $urandom_range(0, GRID_COLS - w);
         if ($urandom_range(0, 19) == 0) begin
            set_area(op, top + h - 1, left + w - 1, top, left);
         end else begin
            set_area(op, top, left, top + h - 1, left + w - 1);
         end
         if (phase == 2) begin
            @(posedge clock);
            rsp_hold = LONG_HOLD;
            @(negedge clock);
         end
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
               send_item(run_item());
            end else if (pick < 5) begin
               send_item(cell_item($urandom_range(0, GRID_ROWS - 1),
                                   $urandom_range(0, GRID_COLS - 1),
                                   KIND_W'($urandom), rand_value()));
            end else begin
               send_item(cell_item(top + $urandom_range(0, h - 1),
                                   left + $urandom_range(0, w - 1),
                                   rand_kind(), rand_value()));
            end
         end
         phase++;
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with none expected: value %0d status %0d count %0d",
                     $time, rsp_data.result_value, rsp_data.status, rsp_data.numeric_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               $display("%0t: result_value expected %0d actual %0d",
                        $time, want.result_value, rsp_data.result_value);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.numeric_count !== want.numeric_count) begin
               $display("%0t: numeric_count expected %0d actual %0d",
                        $time, want.numeric_count, rsp_data.numeric_count);
               errors++;
            end
         end
         rsp_wait = pick_gap(recv_quiet);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_grid();
      test_field_extremes();
      test_inverted_area();
      test_unknown_register();
      test_random_traffic();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
